// ===== design/fem_pkg.sv =====
// Shared constants, types and helper functions of the fisheye to equirect map.
`default_nettype none
package fem_pkg;

   localparam int MAX_DIM_DEF  = 4096;
   localparam int DIM_W        = 13;
   localparam int FOV_W        = 16;
   localparam int PIX_W        = 12;
   localparam int SRC_W        = 14;
   localparam int FRAC_W       = 16;
   localparam int FOV_FRAC_W   = 13;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;

   localparam int RATIO_W      = PIX_W + FRAC_W;
   localparam int RAW_W        = RATIO_W + 3;
   localparam int ANG_W        = 21;
   localparam int UV_W         = 20;
   localparam int AT_W         = 22;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);
   localparam int MOD_STEPS    = 12;

   localparam int PROD_W       = DIM_W + UV_W;
   localparam int RNUM_W       = PROD_W + FOV_FRAC_W;
   localparam int RSPLIT       = 23;
   localparam int PP_W         = (RNUM_W - RSPLIT + 1) + UV_W;
   localparam int SUM_W        = PP_W + RSPLIT + 1;
   localparam int FIN_W        = SUM_W - FRAC_W;

   localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(205887);
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(102944);
   localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = ANG_W'(411775);
   localparam logic signed [UV_W-1:0]  UV_GAIN     = UV_W'(39797);
   localparam logic signed [18:0]      PI_MUL      = 19'sd205887;
   localparam logic signed [RATIO_W:0] RATIO_HALF  = (RATIO_W + 1)'(32768);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_FOV          = 2'd2
   } csr_index_type;

   function automatic logic signed [ANG_W-1:0] atan_of(input logic [STEP_IDX_W-1:0] k);
      case (k)
         4'd0:    atan_of = ANG_W'(51472);
         4'd1:    atan_of = ANG_W'(30386);
         4'd2:    atan_of = ANG_W'(16055);
         4'd3:    atan_of = ANG_W'(8150);
         4'd4:    atan_of = ANG_W'(4091);
         4'd5:    atan_of = ANG_W'(2047);
         4'd6:    atan_of = ANG_W'(1024);
         4'd7:    atan_of = ANG_W'(512);
         4'd8:    atan_of = ANG_W'(256);
         4'd9:    atan_of = ANG_W'(128);
         4'd10:   atan_of = ANG_W'(64);
         4'd11:   atan_of = ANG_W'(32);
         4'd12:   atan_of = ANG_W'(16);
         4'd13:   atan_of = ANG_W'(8);
         4'd14:   atan_of = ANG_W'(4);
         default: atan_of = ANG_W'(2);
      endcase
   endfunction

   // Q16 to integer, truncated toward zero, saturated to the output range.
   function automatic logic signed [SRC_W-1:0] finish_coord(
      input logic signed [FIN_W-1:0] q);
      logic [FIN_W-1:0] mag;
      logic signed [FIN_W-FRAC_W:0] v;
      mag = q[FIN_W-1] ? FIN_W'(-q) : FIN_W'(q);
      v = $signed({1'b0, mag[FIN_W-1:FRAC_W]});
      if (q[FIN_W-1]) begin
         v = -v;
      end
      if (v > (FIN_W - FRAC_W + 1)'(8191)) begin
         finish_coord = SRC_W'(8191);
      end else if (v < -(FIN_W - FRAC_W + 1)'(8192)) begin
         finish_coord = -SRC_W'(8192);
      end else begin
         finish_coord = v[SRC_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

// ===== design/fem_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, tag carried along.
`default_nettype none
module fem_div
   import fem_pkg::*;
#(
   parameter int NUM_W = RATIO_W,
   parameter int DEN_W = DIM_W,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [TAG_W-1:0] out_tag
);

   logic [NUM_W-1:0] vld_ff;
   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W-1];
   logic [TAG_W-1:0] tag_ff [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic             vld_prev;
      logic [NUM_W-1:0] nq_prev;
      logic [DEN_W-1:0] rem_prev;
      logic [TAG_W-1:0] tag_prev;
      logic [DEN_W:0]   trial;
      logic             fits;

      if (s == 0) begin : g_head
         assign vld_prev = in_valid;
         assign nq_prev  = in_num;
         assign rem_prev = '0;
         assign tag_prev = in_tag;
      end else begin : g_body
         assign vld_prev = vld_ff[s-1];
         assign nq_prev  = nq_ff[s-1];
         assign rem_prev = rem_ff[s-1];
         assign tag_prev = tag_ff[s-1];
      end

      assign trial = {rem_prev, nq_prev[NUM_W-1]};
      assign fits  = trial >= {1'b0, in_den};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nq_ff[s]  <= {nq_prev[NUM_W-2:0], fits};
            tag_ff[s] <= tag_prev;
         end
      end

      if (s < NUM_W - 1) begin : g_rem
         logic [DEN_W:0] diff;

         assign diff = trial - {1'b0, in_den};

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s] <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            end
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quo   = nq_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule
`default_nettype wire

// ===== design/fem_mod2pi.sv =====
// Angle reduction modulo 2pi by constant restoring subtraction, one step per stage.
`default_nettype none
module fem_mod2pi
   import fem_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic signed [RAW_W-1:0] in_ang,
   output logic                    out_valid,
   output logic signed [ANG_W-1:0] out_ang
);

   logic [MOD_STEPS-1:0]    vld_ff;
   logic signed [RAW_W-1:0] r_ff [MOD_STEPS];

   for (genvar j = 0; j < MOD_STEPS; j++) begin : g_stage
      localparam logic signed [RAW_W-1:0] SUB =
         RAW_W'(ANG_TWO_PI) <<< (MOD_STEPS - 1 - j);
      logic                    vld_prev;
      logic signed [RAW_W-1:0] r_prev;

      if (j == 0) begin : g_head
         assign vld_prev = in_valid;
         assign r_prev   = in_ang;
      end else begin : g_body
         assign vld_prev = vld_ff[j-1];
         assign r_prev   = r_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (adv) begin
            vld_ff[j] <= vld_prev;
         end
      end

      // negative angles never reach a positive step and pass unchanged
      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[j] <= (r_prev >= SUB) ? r_prev - SUB : r_prev;
         end
      end
   end

   assign out_valid = vld_ff[MOD_STEPS-1];
   assign out_ang   = r_ff[MOD_STEPS-1][ANG_W-1:0];

endmodule
`default_nettype wire

// ===== design/fem_sincos.sv =====
// Rotation CORDIC sine and cosine: wrap and fold stage, 16 micro-rotations, sign stage.
`default_nettype none
module fem_sincos
   import fem_pkg::*;
#(
   parameter int TAG_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic signed [ANG_W-1:0] in_ang,
   input  logic [TAG_W-1:0]        in_tag,
   output logic                    out_valid,
   output logic signed [UV_W-1:0]  out_sin,
   output logic signed [UV_W-1:0]  out_cos,
   output logic [TAG_W-1:0]        out_tag
);

   logic [CORDIC_STEPS:0]   vld_ff;
   logic                    flip_ff [0:CORDIC_STEPS];
   logic [TAG_W-1:0]        tag_ff  [0:CORDIC_STEPS];
   logic signed [ANG_W-1:0] a_ff    [0:CORDIC_STEPS-1];
   logic signed [UV_W-1:0]  x_ff    [1:CORDIC_STEPS];
   logic signed [UV_W-1:0]  y_ff    [1:CORDIC_STEPS];
   logic                    out_vld_ff;
   logic signed [UV_W-1:0]  sin_ff;
   logic signed [UV_W-1:0]  cos_ff;
   logic [TAG_W-1:0]        out_tag_ff;

   logic signed [ANG_W-1:0] wrap_in;
   logic signed [ANG_W-1:0] fold_in;
   logic                    flip_in;

   always_comb begin
      wrap_in = in_ang;
      if (in_ang > ANG_PI) begin
         wrap_in = in_ang - ANG_TWO_PI;
      end else if (in_ang < -ANG_PI) begin
         wrap_in = in_ang + ANG_TWO_PI;
      end
      fold_in = wrap_in;
      flip_in = 1'b0;
      if (wrap_in > ANG_HALF_PI) begin
         fold_in = wrap_in - ANG_PI;
         flip_in = 1'b1;
      end else if (wrap_in < -ANG_HALF_PI) begin
         fold_in = wrap_in + ANG_PI;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff[0]    <= fold_in;
         flip_ff[0] <= flip_in;
         tag_ff[0]  <= in_tag;
      end
   end

   for (genvar i = 1; i <= CORDIC_STEPS; i++) begin : g_step
      localparam int K = i - 1;
      logic signed [UV_W-1:0]  x_prev;
      logic signed [UV_W-1:0]  y_prev;
      logic signed [ANG_W-1:0] a_prev;

      if (i == 1) begin : g_seed
         assign x_prev = UV_GAIN;
         assign y_prev = '0;
      end else begin : g_chain
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
      end
      assign a_prev = a_ff[i-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (a_prev >= 0) begin
               x_ff[i] <= x_prev - (y_prev >>> K);
               y_ff[i] <= y_prev + (x_prev >>> K);
            end else begin
               x_ff[i] <= x_prev + (y_prev >>> K);
               y_ff[i] <= y_prev - (x_prev >>> K);
            end
            flip_ff[i] <= flip_ff[i-1];
            tag_ff[i]  <= tag_ff[i-1];
         end
      end

      if (i < CORDIC_STEPS) begin : g_ang
         logic signed [ANG_W-1:0] step_ang;

         assign step_ang = atan_of(STEP_IDX_W'(K));

         always_ff @(posedge clock) begin
            if (adv) begin
               a_ff[i] <= (a_prev >= 0) ? a_prev - step_ang : a_prev + step_ang;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_ff     <= flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
         cos_ff     <= flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
         out_tag_ff <= tag_ff[CORDIC_STEPS];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_sin   = sin_ff;
   assign out_cos   = cos_ff;
   assign out_tag   = out_tag_ff;

endmodule
`default_nettype wire

// ===== design/fem_atan2.sv =====
// Vectoring CORDIC atan2 and magnitude: quadrant stage, 16 micro-rotations, gain stage.
`default_nettype none
module fem_atan2
   import fem_pkg::*;
#(
   parameter int TAG_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic signed [UV_W-1:0]  in_y,
   input  logic signed [UV_W-1:0]  in_x,
   input  logic [TAG_W-1:0]        in_tag,
   output logic                    out_valid,
   output logic signed [ANG_W-1:0] out_ang,
   output logic signed [UV_W-1:0]  out_mag,
   output logic [TAG_W-1:0]        out_tag
);

   logic [CORDIC_STEPS:0]   vld_ff;
   logic signed [AT_W-1:0]  x_ff   [0:CORDIC_STEPS];
   logic signed [AT_W-1:0]  y_ff   [0:CORDIC_STEPS-1];
   logic signed [ANG_W-1:0] z_ff   [0:CORDIC_STEPS];
   logic [TAG_W-1:0]        tag_ff [0:CORDIC_STEPS];
   logic                    out_vld_ff;
   logic signed [ANG_W-1:0] ang_ff;
   logic signed [UV_W-1:0]  mag_ff;
   logic [TAG_W-1:0]        out_tag_ff;

   logic signed [AT_W-1:0]  x_ext;
   logic signed [AT_W-1:0]  y_ext;
   logic signed [AT_W+UV_W-1:0] gain_prod;

   assign x_ext = AT_W'(in_x);
   assign y_ext = AT_W'(in_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
   end

   // left half plane: negate and start from +/-pi
   always_ff @(posedge clock) begin
      if (adv) begin
         if (in_x < 0) begin
            x_ff[0] <= -x_ext;
            y_ff[0] <= -y_ext;
            z_ff[0] <= (in_y >= 0) ? ANG_PI : -ANG_PI;
         end else begin
            x_ff[0] <= x_ext;
            y_ff[0] <= y_ext;
            z_ff[0] <= '0;
         end
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar i = 1; i <= CORDIC_STEPS; i++) begin : g_step
      localparam int K = i - 1;
      logic signed [AT_W-1:0]  x_prev;
      logic signed [AT_W-1:0]  y_prev;
      logic signed [ANG_W-1:0] step_ang;

      assign x_prev   = x_ff[i-1];
      assign y_prev   = y_ff[i-1];
      assign step_ang = atan_of(STEP_IDX_W'(K));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (y_prev >= 0) begin
               x_ff[i] <= x_prev + (y_prev >>> K);
               z_ff[i] <= z_ff[i-1] + step_ang;
            end else begin
               x_ff[i] <= x_prev - (y_prev >>> K);
               z_ff[i] <= z_ff[i-1] - step_ang;
            end
            tag_ff[i] <= tag_ff[i-1];
         end
      end

      if (i < CORDIC_STEPS) begin : g_y
         always_ff @(posedge clock) begin
            if (adv) begin
               y_ff[i] <= (y_prev >= 0) ? y_prev - (x_prev >>> K)
                                        : y_prev + (x_prev >>> K);
            end
         end
      end
   end

   assign gain_prod = x_ff[CORDIC_STEPS] * UV_GAIN;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff     <= z_ff[CORDIC_STEPS];
         mag_ff     <= UV_W'(gain_prod >>> FRAC_W);
         out_tag_ff <= tag_ff[CORDIC_STEPS];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_ang   = ang_ff;
   assign out_mag   = mag_ff;
   assign out_tag   = out_tag_ff;

endmodule
`default_nettype wire

// ===== design/fisheye_equirect_map_core.sv =====
// Top level: fisheye to equirectangular coordinate map, one pixel per clock.
// Throughput: one beat per cycle; the whole pipeline advances unless rsp is stalled.
// Chain: col/row divider (28), angle reduce (13), CORDIC sin/cos (18), projection (1),
// two CORDIC atan2 (36), radius divider (47), sin/cos (18), output multiply (3).
// Reset clears the valid bits and restores the registers to 1024, 1024 and 25735.
`default_nettype none
module fisheye_equirect_map_core
   import fem_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [PIX_W-1:0]             req_col,
   input  logic [PIX_W-1:0]             req_row,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SRC_W-1:0]      rsp_src_x,
   output logic signed [SRC_W-1:0]      rsp_src_y
);

   logic [DIM_W-1:0] csr_w_ff;
   logic [DIM_W-1:0] csr_h_ff;
   logic [FOV_W-1:0] csr_fov_ff;
   logic [DIM_W-1:0] w_eff;
   logic [DIM_W-1:0] h_eff;
   logic [FOV_W-1:0] f_eff;
   logic             adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_w_ff   <= DIM_W'(1024);
         csr_h_ff   <= DIM_W'(1024);
         csr_fov_ff <= FOV_W'(25735);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  csr_w_ff   <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: csr_h_ff   <= csr_wdata[DIM_W-1:0];
            CSR_FOV:          csr_fov_ff <= csr_wdata[FOV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff = csr_w_ff;
      if (csr_w_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (32'(csr_w_ff) > MAX_DIM) begin
         w_eff = DIM_W'(MAX_DIM);
      end
      h_eff = csr_h_ff;
      if (csr_h_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (32'(csr_h_ff) > MAX_DIM) begin
         h_eff = DIM_W'(MAX_DIM);
      end
      f_eff = (csr_fov_ff == '0) ? FOV_W'(1) : csr_fov_ff;
   end

   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // col/W and row/H in Q16
   logic               col_dv;
   logic               row_dv;
   logic [RATIO_W-1:0] col_ratio;
   logic [RATIO_W-1:0] row_ratio;

   fem_div #(.NUM_W(RATIO_W), .DEN_W(DIM_W), .TAG_W(1)) u_div_col (
      .clock, .reset, .adv,
      .in_valid (req_valid),
      .in_num   ({req_col, FRAC_W'(0)}),
      .in_den   (w_eff),
      .in_tag   (1'b0),
      .out_valid(col_dv),
      .out_quo  (col_ratio),
      .out_tag  ()
   );

   fem_div #(.NUM_W(RATIO_W), .DEN_W(DIM_W), .TAG_W(1)) u_div_row (
      .clock, .reset, .adv,
      .in_valid (req_valid),
      .in_num   ({req_row, FRAC_W'(0)}),
      .in_den   (h_eff),
      .in_tag   (1'b0),
      .out_valid(row_dv),
      .out_quo  (row_ratio),
      .out_tag  ()
   );

   // longitude and latitude, signed Q14.16
   logic                      ang_vld_ff;
   logic signed [RAW_W-1:0]   lon_ff;
   logic signed [RAW_W-1:0]   lat_ff;
   logic signed [RATIO_W:0]   col_ctr;
   logic signed [RATIO_W:0]   row_ctr;
   logic signed [RATIO_W+19:0] lon_prod;
   logic signed [RATIO_W+19:0] lat_prod;

   assign col_ctr  = $signed({1'b0, col_ratio}) - RATIO_HALF;
   assign row_ctr  = $signed({1'b0, row_ratio}) - RATIO_HALF;
   assign lon_prod = col_ctr * PI_MUL;
   assign lat_prod = row_ctr * PI_MUL;

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_vld_ff <= 1'b0;
      end else if (adv) begin
         ang_vld_ff <= col_dv;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lon_ff <= RAW_W'(lon_prod >>> FRAC_W);
         lat_ff <= RAW_W'(lat_prod >>> FRAC_W);
      end
   end

   logic                    lon_md_vld;
   logic                    lat_md_vld;
   logic signed [ANG_W-1:0] lon_md;
   logic signed [ANG_W-1:0] lat_md;

   fem_mod2pi u_mod_lon (
      .clock, .reset, .adv,
      .in_valid (ang_vld_ff),
      .in_ang   (lon_ff),
      .out_valid(lon_md_vld),
      .out_ang  (lon_md)
   );

   fem_mod2pi u_mod_lat (
      .clock, .reset, .adv,
      .in_valid (ang_vld_ff),
      .in_ang   (lat_ff),
      .out_valid(lat_md_vld),
      .out_ang  (lat_md)
   );

   logic                   lon_sc_vld;
   logic                   lat_sc_vld;
   logic signed [UV_W-1:0] sl;
   logic signed [UV_W-1:0] cl;
   logic signed [UV_W-1:0] sp;
   logic signed [UV_W-1:0] cp;

   fem_sincos #(.TAG_W(1)) u_sc_lon (
      .clock, .reset, .adv,
      .in_valid (lon_md_vld),
      .in_ang   (lon_md),
      .in_tag   (1'b0),
      .out_valid(lon_sc_vld),
      .out_sin  (sl),
      .out_cos  (cl),
      .out_tag  ()
   );

   fem_sincos #(.TAG_W(1)) u_sc_lat (
      .clock, .reset, .adv,
      .in_valid (lat_md_vld),
      .in_ang   (lat_md),
      .in_tag   (1'b0),
      .out_valid(lat_sc_vld),
      .out_sin  (sp),
      .out_cos  (cp)
      , .out_tag()
   );

   // point on the unit sphere
   logic                     proj_vld_ff;
   logic signed [UV_W-1:0]   px_ff;
   logic signed [UV_W-1:0]   py_ff;
   logic signed [UV_W-1:0]   pz_ff;
   logic signed [2*UV_W-1:0] cpsl;
   logic signed [2*UV_W-1:0] cpcl;

   assign cpsl = cp * sl;
   assign cpcl = cp * cl;

   always_ff @(posedge clock) begin
      if (reset) begin
         proj_vld_ff <= 1'b0;
      end else if (adv) begin
         proj_vld_ff <= lon_sc_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= UV_W'(cpsl >>> FRAC_W);
         py_ff <= UV_W'(cpcl >>> FRAC_W);
         pz_ff <= sp;
      end
   end

   // azimuth and in-plane magnitude, py carried along
   logic                    az_vld;
   logic signed [ANG_W-1:0] az;
   logic signed [UV_W-1:0]  pm;
   logic [UV_W-1:0]         py_d;

   fem_atan2 #(.TAG_W(UV_W)) u_atan_az (
      .clock, .reset, .adv,
      .in_valid (proj_vld_ff),
      .in_y     (pz_ff),
      .in_x     (px_ff),
      .in_tag   (py_ff),
      .out_valid(az_vld),
      .out_ang  (az),
      .out_mag  (pm),
      .out_tag  (py_d)
   );

   // polar angle, azimuth carried along
   logic                    pol_vld;
   logic signed [ANG_W-1:0] polar;
   logic [ANG_W-1:0]        az_d;

   fem_atan2 #(.TAG_W(ANG_W)) u_atan_pol (
      .clock, .reset, .adv,
      .in_valid (az_vld),
      .in_y     (pm),
      .in_x     ($signed(py_d)),
      .in_tag   (az),
      .out_valid(pol_vld),
      .out_ang  (polar),
      .out_mag  (),
      .out_tag  (az_d)
   );

   // W * polar, negative polar clamped to zero
   logic              rscl_vld_ff;
   logic [PROD_W-1:0] wp_ff;
   logic [ANG_W-1:0]  az_r_ff;
   logic [UV_W-1:0]   pol_c;
   logic [PROD_W-1:0] wp_in;

   assign pol_c = polar[ANG_W-1] ? '0 : polar[UV_W-1:0];
   assign wp_in = w_eff * pol_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         rscl_vld_ff <= 1'b0;
      end else if (adv) begin
         rscl_vld_ff <= pol_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wp_ff   <= wp_in;
         az_r_ff <= az_d;
      end
   end

   // r = W * polar * 8192 / fov
   logic              r_vld;
   logic [RNUM_W-1:0] r_q;
   logic [ANG_W-1:0]  az_q;

   fem_div #(.NUM_W(RNUM_W), .DEN_W(FOV_W), .TAG_W(ANG_W)) u_div_r (
      .clock, .reset, .adv,
      .in_valid (rscl_vld_ff),
      .in_num   ({wp_ff, FOV_FRAC_W'(0)}),
      .in_den   (f_eff),
      .in_tag   (az_r_ff),
      .out_valid(r_vld),
      .out_quo  (r_q),
      .out_tag  (az_q)
   );

   logic                   az_sc_vld;
   logic signed [UV_W-1:0] sa;
   logic signed [UV_W-1:0] ca;
   logic [RNUM_W-1:0]      r_d;

   fem_sincos #(.TAG_W(RNUM_W)) u_sc_az (
      .clock, .reset, .adv,
      .in_valid (r_vld),
      .in_ang   ($signed(az_q)),
      .in_tag   (r_q),
      .out_valid(az_sc_vld),
      .out_sin  (sa),
      .out_cos  (ca),
      .out_tag  (r_d)
   );

   // r * cos and r * sin as two partial products each
   logic                   mula_vld_ff;
   logic signed [PP_W-1:0] phx_ff;
   logic signed [PP_W-1:0] plx_ff;
   logic signed [PP_W-1:0] phy_ff;
   logic signed [PP_W-1:0] ply_ff;
   logic signed [PP_W-1:0] phx_in;
   logic signed [PP_W-1:0] plx_in;
   logic signed [PP_W-1:0] phy_in;
   logic signed [PP_W-1:0] ply_in;
   logic signed [RNUM_W-RSPLIT:0] r_hi;
   logic signed [RSPLIT:0]        r_lo;

   assign r_hi   = $signed({1'b0, r_d[RNUM_W-1:RSPLIT]});
   assign r_lo   = $signed({1'b0, r_d[RSPLIT-1:0]});
   assign phx_in = r_hi * ca;
   assign plx_in = r_lo * ca;
   assign phy_in = r_hi * sa;
   assign ply_in = r_lo * sa;

   always_ff @(posedge clock) begin
      if (reset) begin
         mula_vld_ff <= 1'b0;
      end else if (adv) begin
         mula_vld_ff <= az_sc_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         phx_ff <= phx_in;
         plx_ff <= plx_in;
         phy_ff <= phy_in;
         ply_ff <= ply_in;
      end
   end

   // centre + floor(r * trig / 2^16), still Q16
   logic                    mulb_vld_ff;
   logic signed [FIN_W-1:0] qx_ff;
   logic signed [FIN_W-1:0] qy_ff;
   logic signed [SUM_W-1:0] sum_x;
   logic signed [SUM_W-1:0] sum_y;
   logic signed [FIN_W-1:0] shx;
   logic signed [FIN_W-1:0] shy;
   logic signed [DIM_W+15:0] ctr_x;
   logic signed [DIM_W+15:0] ctr_y;

   assign sum_x = (SUM_W'(phx_ff) <<< RSPLIT) + SUM_W'(plx_ff);
   assign sum_y = (SUM_W'(phy_ff) <<< RSPLIT) + SUM_W'(ply_ff);
   assign shx   = FIN_W'(sum_x >>> FRAC_W);
   assign shy   = FIN_W'(sum_y >>> FRAC_W);
   assign ctr_x = $signed({1'b0, w_eff, 15'b0});
   assign ctr_y = $signed({1'b0, h_eff, 15'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         mulb_vld_ff <= 1'b0;
      end else if (adv) begin
         mulb_vld_ff <= mula_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff <= shx + FIN_W'(ctr_x);
         qy_ff <= shy + FIN_W'(ctr_y);
      end
   end

   logic signed [SRC_W-1:0] src_x_ff;
   logic signed [SRC_W-1:0] src_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= mulb_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         src_x_ff <= finish_coord(qx_ff);
         src_y_ff <= finish_coord(qy_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_src_x = src_x_ff;
   assign rsp_src_y = src_y_ff;

   a_div_lanes: assert property (@(posedge clock) disable iff (reset)
      col_dv == row_dv)
      else $error("col and row dividers out of step");

   a_sc_lanes: assert property (@(posedge clock) disable iff (reset)
      (lon_md_vld == lat_md_vld) && (lon_sc_vld == lat_sc_vld))
      else $error("longitude and latitude lanes out of step");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      lon_sc_vld |-> (cl <= UV_W'(70000)) && (cl >= -UV_W'(70000))
                  && (sl <= UV_W'(70000)) && (sl >= -UV_W'(70000)))
      else $error("sin/cos outside unit range");

endmodule
`default_nettype wire
